FILE: src/utf8_stream_decoder_unit_macros.svh
// Assertion macros for the UTF-8 stream decoder.
// Uses the clk and rst_n names of the module that includes it.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/usd_pkg.sv
// Shared types, constants and decode functions for the UTF-8 stream decoder.
// No dependencies.
package usd_pkg;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_C0     = 8'hC0;
  localparam logic [7:0] LEAD_C1     = 8'hC1;
  localparam logic [7:0] LEAD_F5     = 8'hF5;
  localparam logic [2:0] TAG_LEAD2   = 3'b110;
  localparam logic [3:0] TAG_LEAD3   = 4'hE;
  localparam logic [4:0] TAG_LEAD4   = 5'h1E;
  localparam logic [1:0] TAG_CONT    = 2'b10;

  localparam int CP_W  = 21;
  localparam int LEN_W = 3;

  // One decode step taken from the front of the byte buffer.
  typedef struct packed {
    logic             valid;   // a result can be produced
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             bad;
  } step_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // append the accepted byte
    logic emit;   // move the current step into the output register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic has_result;  // current buffer yields a result
    logic more;        // buffer after this result still yields one
    logic out_free;    // output register can take a result
  } dp_stat_t;

  function automatic logic [2:0] lead_length(input logic [7:0] c);
    logic [2:0] len;
    if (c < ASCII_LIMIT) begin
      len = 3'd1;
    end else if (c == LEAD_C0 || c == LEAD_C1 || c >= LEAD_F5) begin
      len = 3'd0;
    end else if (c[7:5] == TAG_LEAD2) begin
      len = 3'd2;
    end else if (c[7:4] == TAG_LEAD3) begin
      len = 3'd3;
    end else if (c[7:3] == TAG_LEAD4) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == TAG_CONT;
  endfunction

  // Decode from b[0] with n bytes held (0..4).
  function automatic step_t decode_step(input logic [3:0][7:0] b, input logic [2:0] n,
                                        input logic eos);
    step_t      s;
    logic [2:0] len;
    logic       bad;
    logic [7:0] c;
    c   = b[0];
    len = lead_length(c);
    bad = (len == 3'd0);
    if (len >= 3'd2 && n >= 3'd2 && !is_cont(b[1])) bad = 1'b1;
    if (len >= 3'd3 && n >= 3'd3 && !is_cont(b[2])) bad = 1'b1;
    if (len == 3'd4 && n == 3'd4 && !is_cont(b[3])) bad = 1'b1;
    s.valid = (n != 3'd0);
    if (!bad && n < len) begin
      if (eos) begin
        bad = 1'b1;
      end else begin
        s.valid = 1'b0;
      end
    end
    s.bad = bad;
    s.len = bad ? 3'd1 : len;
    if (bad) begin
      s.cp = {13'd0, c};
    end else begin
      case (len)
        3'd2:    s.cp = {10'd0, c[4:0], b[1][5:0]};
        3'd3:    s.cp = {5'd0, c[3:0], b[1][5:0], b[2][5:0]};
        3'd4:    s.cp = {c[2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
        default: s.cp = {13'd0, c};
      endcase
    end
    return s;
  endfunction

endpackage

FILE: src/usd_ctrl.sv
// Controller for the UTF-8 stream decoder: accept / scan sequencing.
// Depends on usd_pkg.
module usd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  usd_pkg::dp_stat_t stat,
  output usd_pkg::ctl_cmd_t cmd
);
  import usd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.has_result) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.more) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/usd_dp.sv
// Datapath for the UTF-8 stream decoder: byte buffer, decode step, output register.
// Depends on usd_pkg.
module usd_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  usd_pkg::ctl_cmd_t        cmd,
  output usd_pkg::dp_stat_t        stat,
  input  logic [7:0]               in_byte,
  input  logic                     in_eos,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [usd_pkg::CP_W-1:0] out_cp,
  output logic [usd_pkg::LEN_W-1:0] out_len,
  output logic                     out_bad,
  output logic                     out_last
);
  import usd_pkg::*;

  logic [3:0][7:0]  buf_r, buf_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             eos_r;
  logic [3:0][7:0]  buf_shift;
  logic [2:0]       cnt_shift;
  step_t            cur, nxt_step;
  logic             out_valid_r;
  logic [CP_W-1:0]  out_cp_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_bad_r;
  logic             out_last_r;

  assign cur = decode_step(buf_r, cnt_r, eos_r);

  // Drop the bytes the current result consumes.
  always_comb begin
    case (cur.len)
      3'd1:    buf_shift = {8'h00, buf_r[3:1]};
      3'd2:    buf_shift = {16'h0000, buf_r[3:2]};
      3'd3:    buf_shift = {24'h000000, buf_r[3]};
      3'd4:    buf_shift = '0;
      default: buf_shift = buf_r;
    endcase
  end
  assign cnt_shift = cnt_r - cur.len;
  assign nxt_step  = decode_step(buf_shift, cnt_shift, eos_r);

  assign stat.has_result = cur.valid;
  assign stat.more       = nxt_step.valid;
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      buf_nxt[cnt_r[1:0]] = in_byte;
      cnt_nxt             = cnt_r + 3'd1;
    end else if (cmd.emit) begin
      buf_nxt = buf_shift;
      cnt_nxt = cnt_shift;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.load) eos_r <= in_eos;
    if (cmd.emit) begin
      out_cp_r   <= cur.cp;
      out_len_r  <= cur.len;
      out_bad_r  <= cur.bad;
      out_last_r <= !nxt_step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_cp    = out_cp_r;
  assign out_len   = out_len_r;
  assign out_bad   = out_bad_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder. One byte is taken per input transfer (in_tlast marks the
// last byte of the stream) and zero to four decoded results leave per byte on the
// output channel. Each result carries a code point and the number of stream bytes it
// consumed; a bad lead byte (C0, C1, F5..FF, a stray continuation, a lead followed by
// a non-continuation, or a sequence cut short by end of stream) comes out raw with
// length 1 and out_tuser set, and the bytes after it are decoded again. Overlong
// forms led by E0/F0 and surrogates are not rejected. out_tlast marks the last result
// caused by an input byte. Sequencing: an input byte is taken in the accept state, then
// the scan step in the controller releases its results one per cycle through the single
// output register while that register is free; a stalled output holds the scan, and no
// new byte is taken until the scan ends. A byte that only extends a pending sequence still
// passes through the scan state. The output register lets the next byte be taken while
// the last result still waits for out_tready.
// Depends on usd_pkg, usd_ctrl, usd_dp and the assertion macro header.
`include "utf8_stream_decoder_unit_macros.svh"

module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] code_point, [23:21] seq_length
  output logic        out_tuser,   // malformed
  output logic        out_tlast    // last_result
);
  import usd_pkg::*;

  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic [CP_W-1:0]  out_cp;
  logic [LEN_W-1:0] out_len;

  // Sequence: accept a byte, then scan out results one per cycle while the output register is free.
  usd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold pending bytes, decode from the front, register each result.
  usd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_cp    (out_cp),
    .out_len   (out_len),
    .out_bad   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_len, out_cp};

  // A raw byte always reports length 1.
  `USD_ASSERT_NOW(a_bad_len_one, out_tvalid && out_tuser, out_tdata[23:21] == 3'd1, "malformed result with length other than 1")
  // Lengths stay within one to four bytes.
  `USD_ASSERT_NOW(a_len_range, out_tvalid, out_tdata[23:21] != 3'd0 && out_tdata[23:21] <= 3'd4, "result length out of range")
  // Never emit in the cycle a byte is taken.
  `USD_ASSERT_NOW(a_no_emit_on_load, in_tvalid && in_tready, !cmd.emit, "emit during input transfer")
  // Emitting the final result of a byte returns to accepting input.
  `USD_ASSERT_NEXT(a_last_frees_input, cmd.emit && !stat.more, in_tready, "input not ready after final result")

endmodule
